FILE: rtl/i2cebm_pkg.sv
// package: types and constants for the i2c eeprom byte master
`default_nettype none

package i2cebm_pkg;

  // command codes carried in tuser
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // register map, byte address 4*index
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic REG_DEV_ADDR  = 1'b0;
  localparam logic REG_WAIT_TICK = 1'b1;

  localparam logic [6:0]  DEV_ADDR_RESET  = 7'd80;
  localparam logic [19:0] WAIT_TICK_RESET = 20'd20000;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 16;

  // bus sequence, one-hot
  typedef enum logic [14:0] {
    ST_IDLE   = 15'b000000000000001,
    ST_START  = 15'b000000000000010,
    ST_DEVW   = 15'b000000000000100,
    ST_ACKDW  = 15'b000000000001000,
    ST_ADDR   = 15'b000000000010000,
    ST_ACKA   = 15'b000000000100000,
    ST_DATA   = 15'b000000001000000,
    ST_ACKD   = 15'b000000010000000,
    ST_RSTART = 15'b000000100000000,
    ST_DEVR   = 15'b000001000000000,
    ST_ACKDR  = 15'b000010000000000,
    ST_READ   = 15'b000100000000000,
    ST_NACK   = 15'b001000000000000,
    ST_STOP   = 15'b010000000000000,
    ST_WAIT   = 15'b100000000000000
  } step_t;

  // one result item
  typedef struct packed {
    logic       rejected;
    logic       burst_done;
    logic       byte_done;
    logic       busy_res;
    logic [7:0] read_data;
    logic       sda_release;
    logic       scl;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/i2c_eeprom_byte_master_top.sv
// top level: tick-driven i2c master for byte write and random read of a serial eeprom
//
//  channel | direction | payload
//  in_     | request   | tdata: address[7:0], write_data[15:8], sda_in[16], zero[23:17];
//          |           | tuser: command[1:0]; tlast: final_byte
//  out_    | result    | tdata: scl[0], sda_release[1], read_data[9:2], busy_res[10],
//          |           | byte_done[11], burst_done[12], rejected[13], zero[15:14]
//  cfg_    | apb       | 0x0 device_address[6:0], 0x4 write_wait_ticks[19:0]
//
// one request per clock while out_ is not stalled; each request is one quarter-bit tick and yields one result
// the sequencer state updates at the accepting edge, the result sits in an output register
// a request is taken whenever the output register is empty or being drained
// a stall on out_ holds the whole block; no tick is lost or repeated
// rst_n is synchronous: sequencer idle, phase, counters and registers to reset values
`default_nettype none

module i2c_eeprom_byte_master_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [i2cebm_pkg::IN_DATA_W-1:0]    in_tdata,  // address, write_data, sda_in
  input  wire logic [1:0]                          in_tuser,  // command
  input  wire logic                                in_tlast,  // final_byte
  // result stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [i2cebm_pkg::OUT_DATA_W-1:0]        out_tdata, // scl, sda_release, read_data,
                                                              // busy_res, byte_done,
                                                              // burst_done, rejected
  // configuration
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [i2cebm_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [31:0]                         cfg_pwdata,
  output logic [31:0]                              cfg_prdata,
  output logic                                     cfg_pready
);

  // configuration registers
  logic [6:0]  dev_addr_r;
  logic [19:0] wait_ticks_r;

  // sequencer state
  i2cebm_pkg::step_t step_r, step_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [3:0]  bits_r, bits_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  offset_r, offset_nxt;
  logic [7:0]  hold_addr_r, hold_addr_nxt;
  logic [7:0]  hold_data_r, hold_data_nxt;
  logic        is_read_r, is_read_nxt;
  logic        is_final_r, is_final_nxt;
  logic [19:0] wait_r, wait_nxt;
  logic [7:0]  last_read_r, last_read_nxt;

  // output stage
  logic                  out_valid_r;
  i2cebm_pkg::result_t   res_r, res_nxt;

  // request fields
  logic [1:0] cmd;
  logic [7:0] req_addr;
  logic [7:0] req_data;
  logic       req_sda;
  logic       request;
  logic       accept;

  logic       last_q;
  logic       bitclk;
  logic       scl_c, rel_c, bdone_c, bfinal_c, rej_c;
  logic       cfg_wr;

  assign cmd      = in_tuser;
  assign req_addr = in_tdata[7:0];
  assign req_data = in_tdata[15:8];
  assign req_sda  = in_tdata[16];
  assign request  = (cmd == i2cebm_pkg::CMD_WRITE) || (cmd == i2cebm_pkg::CMD_READ);

  // output register frees up when drained, so a tick can enter every cycle
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign last_q = (phase_r == 2'd3);
  assign bitclk = (phase_r == 2'd1) || (phase_r == 2'd2);

  // ---------------------------------------------------------------------------
  // one tick of the bus sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    step_nxt      = step_r;
    phase_nxt     = phase_r;
    bits_nxt      = bits_r;
    shift_nxt     = shift_r;
    offset_nxt    = offset_r;
    hold_addr_nxt = hold_addr_r;
    hold_data_nxt = hold_data_r;
    is_read_nxt   = is_read_r;
    is_final_nxt  = is_final_r;
    wait_nxt      = wait_r;
    last_read_nxt = last_read_r;
    scl_c    = 1'b1;
    rel_c    = 1'b1;
    bdone_c  = 1'b0;
    bfinal_c = 1'b0;
    rej_c    = 1'b0;

    if (step_r == i2cebm_pkg::ST_IDLE) begin
      // idle levels still driven on the accepting tick
      if (request) begin
        hold_addr_nxt = req_addr + offset_r;
        hold_data_nxt = req_data;
        is_read_nxt   = (cmd == i2cebm_pkg::CMD_READ);
        is_final_nxt  = in_tlast;
        step_nxt      = i2cebm_pkg::ST_START;
        phase_nxt     = 2'd0;
      end
    end else begin
      rej_c = request;
      unique case (step_r)
        i2cebm_pkg::ST_START, i2cebm_pkg::ST_RSTART: begin
          // sda falls while scl is high
          scl_c = !last_q;
          rel_c = !phase_r[1];
          if (last_q) begin
            bits_nxt = 4'd8;
            if (step_r == i2cebm_pkg::ST_START) begin
              step_nxt  = i2cebm_pkg::ST_DEVW;
              shift_nxt = {dev_addr_r, 1'b0};
            end else begin
              step_nxt  = i2cebm_pkg::ST_DEVR;
              shift_nxt = {dev_addr_r, 1'b1};
            end
          end
        end
        i2cebm_pkg::ST_DEVW, i2cebm_pkg::ST_ADDR,
        i2cebm_pkg::ST_DATA, i2cebm_pkg::ST_DEVR: begin
          scl_c = bitclk;
          rel_c = shift_r[7];
          if (last_q) begin
            shift_nxt = {shift_r[6:0], 1'b0};
            bits_nxt  = bits_r - 4'd1;
            if (bits_nxt == 4'd0) begin
              // each send state is followed by its ack slot
              priority case (1'b1)
                step_r == i2cebm_pkg::ST_DEVW: step_nxt = i2cebm_pkg::ST_ACKDW;
                step_r == i2cebm_pkg::ST_ADDR: step_nxt = i2cebm_pkg::ST_ACKA;
                step_r == i2cebm_pkg::ST_DATA: step_nxt = i2cebm_pkg::ST_ACKD;
                default:                       step_nxt = i2cebm_pkg::ST_ACKDR;
              endcase
            end
          end
        end
        i2cebm_pkg::ST_ACKDW, i2cebm_pkg::ST_ACKA, i2cebm_pkg::ST_ACKD,
        i2cebm_pkg::ST_ACKDR, i2cebm_pkg::ST_NACK: begin
          // sda released; slave ack is clocked but not checked
          scl_c = bitclk;
          if (last_q) begin
            priority if (step_r == i2cebm_pkg::ST_ACKDW) begin
              step_nxt  = i2cebm_pkg::ST_ADDR;
              shift_nxt = hold_addr_r;
              bits_nxt  = 4'd8;
            end else if (step_r == i2cebm_pkg::ST_ACKA) begin
              if (is_read_r) begin
                step_nxt = i2cebm_pkg::ST_RSTART;
              end else begin
                step_nxt  = i2cebm_pkg::ST_DATA;
                shift_nxt = hold_data_r;
                bits_nxt  = 4'd8;
              end
            end else if (step_r == i2cebm_pkg::ST_ACKDR) begin
              step_nxt  = i2cebm_pkg::ST_READ;
              shift_nxt = 8'd0;
              bits_nxt  = 4'd8;
            end else begin
              step_nxt = i2cebm_pkg::ST_STOP;
            end
          end
        end
        i2cebm_pkg::ST_READ: begin
          scl_c = bitclk;
          // sample in the second high quarter, msb first
          if (phase_r == 2'd2) begin
            shift_nxt = {shift_r[6:0], req_sda};
          end
          if (last_q) begin
            bits_nxt = bits_r - 4'd1;
            if (bits_nxt == 4'd0) begin
              last_read_nxt = shift_r;
              step_nxt      = i2cebm_pkg::ST_NACK;
            end
          end
        end
        i2cebm_pkg::ST_STOP: begin
          // sda rises while scl is high
          scl_c = (phase_r != 2'd0);
          rel_c = phase_r[1];
          if (last_q) begin
            if (!is_read_r && (wait_ticks_r != 20'd0)) begin
              step_nxt = i2cebm_pkg::ST_WAIT;
              wait_nxt = wait_ticks_r;
            end else begin
              bdone_c    = 1'b1;
              bfinal_c   = is_final_r;
              offset_nxt = is_final_r ? 8'd0 : offset_r + 8'd1;
              step_nxt   = i2cebm_pkg::ST_IDLE;
            end
          end
        end
        i2cebm_pkg::ST_WAIT: begin
          // write cycle of the eeprom
          if (wait_r != 20'd0) begin
            wait_nxt = wait_r - 20'd1;
          end
          if (wait_nxt == 20'd0) begin
            bdone_c    = 1'b1;
            bfinal_c   = is_final_r;
            offset_nxt = is_final_r ? 8'd0 : offset_r + 8'd1;
            step_nxt   = i2cebm_pkg::ST_IDLE;
          end
        end
        default: begin
          step_nxt = i2cebm_pkg::ST_IDLE;
        end
      endcase
      if ((step_nxt != i2cebm_pkg::ST_IDLE) && (step_nxt != i2cebm_pkg::ST_WAIT)) begin
        phase_nxt = phase_r + 2'd1;
      end else begin
        phase_nxt = 2'd0;
      end
    end

    res_nxt.scl         = scl_c;
    res_nxt.sda_release = rel_c;
    res_nxt.read_data   = last_read_nxt;
    res_nxt.busy_res    = (step_nxt != i2cebm_pkg::ST_IDLE);
    res_nxt.byte_done   = bdone_c;
    res_nxt.burst_done  = bfinal_c;
    res_nxt.rejected    = rej_c;
  end

  // sequencer registers advance only on an accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= i2cebm_pkg::ST_IDLE;
      phase_r     <= 2'd0;
      bits_r      <= 4'd0;
      shift_r     <= 8'd0;
      offset_r    <= 8'd0;
      hold_addr_r <= 8'd0;
      hold_data_r <= 8'd0;
      is_read_r   <= 1'b0;
      is_final_r  <= 1'b0;
      wait_r      <= 20'd0;
      last_read_r <= 8'd0;
    end else if (accept) begin
      step_r      <= step_nxt;
      phase_r     <= phase_nxt;
      bits_r      <= bits_nxt;
      shift_r     <= shift_nxt;
      offset_r    <= offset_nxt;
      hold_addr_r <= hold_addr_nxt;
      hold_data_r <= hold_data_nxt;
      is_read_r   <= is_read_nxt;
      is_final_r  <= is_final_nxt;
      wait_r      <= wait_nxt;
      last_read_r <= last_read_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(i2cebm_pkg::OUT_DATA_W - $bits(i2cebm_pkg::result_t)){1'b0}}, res_r};

  // ---------------------------------------------------------------------------
  // configuration port, register index from paddr[2]
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r   <= i2cebm_pkg::DEV_ADDR_RESET;
      wait_ticks_r <= i2cebm_pkg::WAIT_TICK_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == i2cebm_pkg::REG_DEV_ADDR) begin
        dev_addr_r <= cfg_pwdata[6:0];
      end else begin
        wait_ticks_r <= cfg_pwdata[19:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == i2cebm_pkg::REG_WAIT_TICK) begin
      cfg_prdata = {12'd0, wait_ticks_r};
    end else begin
      cfg_prdata = {25'd0, dev_addr_r};
    end
  end

endmodule

`default_nettype wire

FILE: bench/i2cebm_checker.sv
// checker for the i2c eeprom byte master: predicts each tick result and compares it
module i2cebm_checker (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  input  wire logic                                in_tready,
  input  wire logic [i2cebm_pkg::IN_DATA_W-1:0]    in_tdata,  // address, write_data, sda_in
  input  wire logic [1:0]                          in_tuser,  // command
  input  wire logic                                in_tlast,  // final_byte
  input  wire logic                                out_tvalid,
  input  wire logic                                out_tready,
  input  wire logic [i2cebm_pkg::OUT_DATA_W-1:0]   out_tdata, // scl, sda_release, read_data,
                                                              // busy_res, byte_done,
                                                              // burst_done, rejected
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [i2cebm_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [31:0]                         cfg_pwdata,
  input  wire logic [31:0]                         cfg_prdata,
  input  wire logic                                cfg_pready,
  output int                                       errors,
  output int                                       pending,
  output logic                                     seq_busy
);
  timeunit 1ns;
  timeprecision 1ps;

  import i2cebm_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] DEV_REG_ADDR  = {REG_DEV_ADDR, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] WAIT_REG_ADDR = {REG_WAIT_TICK, 2'b00};

  // register copy
  logic [6:0]  dev_addr;
  logic [19:0] wait_ticks;

  // sequencer copy
  step_t       seq_step;
  logic [1:0]  qphase;
  logic [3:0]  bits_left;
  logic [7:0]  shreg;
  logic [7:0]  burst_ofs;
  logic [7:0]  held_addr;
  logic [7:0]  held_data;
  logic        rd_flag;
  logic        fin_flag;
  logic [19:0] wait_cnt;
  logic [7:0]  last_rd;

  result_t due_results[$];
  int      n_results;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= 30)
      $display("%0t mismatch %s at result %0d: got %0h want %0h",
               $time, what, n_results, got, want);
  endtask

  task automatic load_shift(input step_t nxt, input logic [7:0] b);
    seq_step  = nxt;
    shreg     = b;
    bits_left = 4'd8;
  endtask

  task automatic close_byte(inout result_t r);
    r.byte_done  = 1'b1;
    r.burst_done = fin_flag;
    burst_ofs    = fin_flag ? 8'd0 : burst_ofs + 8'd1;
    seq_step     = ST_IDLE;
    qphase       = 2'd0;
  endtask

  // one quarter-bit tick of the bus
  task automatic bus_tick(input logic [1:0] cmd, input logic [7:0] addr, input logic [7:0] wd,
                          input logic fin, input logic sda, output result_t r);
    logic       req;
    logic [1:0] q;
    logic       last_q;
    logic       bitclk;
    req    = (cmd == CMD_WRITE) || (cmd == CMD_READ);
    q      = qphase;
    last_q = (q == 2'd3);
    bitclk = (q == 2'd1) || (q == 2'd2);
    r = '0;
    r.scl = 1'b1;
    r.sda_release = 1'b1;
    if (seq_step == ST_IDLE) begin
      if (req) begin
        held_addr = addr + burst_ofs;
        held_data = wd;
        rd_flag   = (cmd == CMD_READ);
        fin_flag  = fin;
        seq_step  = ST_START;
        qphase    = 2'd0;
      end
    end else begin
      r.rejected = req;
      case (seq_step)
        ST_START, ST_RSTART: begin
          r.scl = (q != 2'd3);
          r.sda_release = (q < 2'd2);
          if (last_q) begin
            if (seq_step == ST_START) load_shift(ST_DEVW, {dev_addr, 1'b0});
            else load_shift(ST_DEVR, {dev_addr, 1'b1});
          end
        end
        ST_DEVW, ST_ADDR, ST_DATA, ST_DEVR: begin
          r.scl = bitclk;
          r.sda_release = shreg[7];
          if (last_q) begin
            shreg = shreg << 1;
            bits_left = bits_left - 4'd1;
            if (bits_left == 4'd0) begin
              case (seq_step)
                ST_DEVW: seq_step = ST_ACKDW;
                ST_ADDR: seq_step = ST_ACKA;
                ST_DATA: seq_step = ST_ACKD;
                default: seq_step = ST_ACKDR;
              endcase
            end
          end
        end
        ST_ACKDW, ST_ACKA, ST_ACKD, ST_ACKDR, ST_NACK: begin
          r.scl = bitclk;
          if (last_q) begin
            case (seq_step)
              ST_ACKDW: load_shift(ST_ADDR, held_addr);
              ST_ACKA: begin
                if (rd_flag) seq_step = ST_RSTART;
                else load_shift(ST_DATA, held_data);
              end
              ST_ACKDR: load_shift(ST_READ, 8'd0);
              default:  seq_step = ST_STOP;
            endcase
          end
        end
        ST_READ: begin
          r.scl = bitclk;
          if (q == 2'd2) shreg = {shreg[6:0], sda};
          if (last_q) begin
            bits_left = bits_left - 4'd1;
            if (bits_left == 4'd0) begin
              last_rd  = shreg;
              seq_step = ST_NACK;
            end
          end
        end
        ST_STOP: begin
          r.scl = (q != 2'd0);
          r.sda_release = (q >= 2'd2);
          if (last_q) begin
            if (!rd_flag && wait_ticks != 20'd0) begin
              seq_step = ST_WAIT;
              wait_cnt = wait_ticks;
            end else begin
              close_byte(r);
            end
          end
        end
        ST_WAIT: begin
          if (wait_cnt != 20'd0) wait_cnt = wait_cnt - 20'd1;
          if (wait_cnt == 20'd0) close_byte(r);
        end
        default: seq_step = ST_IDLE;
      endcase
      if (seq_step != ST_IDLE && seq_step != ST_WAIT) qphase = q + 2'd1;
      else qphase = 2'd0;
    end
    r.read_data = last_rd;
    r.busy_res  = (seq_step != ST_IDLE);
  endtask

  initial begin
    errors   = 0;
    pending  = 0;
    seq_busy = 1'b0;
  end

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    result_t nxt;
    if (!rst_n) begin
      dev_addr   = DEV_ADDR_RESET;
      wait_ticks = WAIT_TICK_RESET;
      seq_step   = ST_IDLE;
      qphase     = '0;
      bits_left  = '0;
      shreg      = '0;
      burst_ofs  = '0;
      held_addr  = '0;
      held_data  = '0;
      rd_flag    = 1'b0;
      fin_flag   = 1'b0;
      wait_cnt   = '0;
      last_rd    = '0;
      n_results  = 0;
      due_results.delete();
    end else begin
      // older result leaves before the new request is predicted
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing due", out_tdata, 0);
        end else begin
          want = due_results.pop_front();
          got  = out_tdata[13:0];
          if (got.scl !== want.scl) report_mismatch("scl", got.scl, want.scl);
          if (got.sda_release !== want.sda_release)
            report_mismatch("sda_release", got.sda_release, want.sda_release);
          if (got.read_data !== want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
          if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", got.busy_res, want.busy_res);
          if (got.byte_done !== want.byte_done)
            report_mismatch("byte_done", got.byte_done, want.byte_done);
          if (got.burst_done !== want.burst_done)
            report_mismatch("burst_done", got.burst_done, want.burst_done);
          if (got.rejected !== want.rejected)
            report_mismatch("rejected", got.rejected, want.rejected);
          if (out_tdata[15:14] !== 2'b00)
            report_mismatch("pad bits", out_tdata[15:14], 0);
        end
        n_results++;
      end
      if (in_tvalid && in_tready) begin
        bus_tick(in_tuser, in_tdata[7:0], in_tdata[15:8], in_tlast, in_tdata[16], nxt);
        due_results.push_back(nxt);
      end
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          case (cfg_paddr)
            DEV_REG_ADDR:  dev_addr   = cfg_pwdata[6:0];
            WAIT_REG_ADDR: wait_ticks = cfg_pwdata[19:0];
            default: ;
          endcase
        end else begin
          case (cfg_paddr)
            DEV_REG_ADDR:
              if (cfg_prdata !== {25'd0, dev_addr})
                report_mismatch("device_address readback", cfg_prdata, dev_addr);
            WAIT_REG_ADDR:
              if (cfg_prdata !== {12'd0, wait_ticks})
                report_mismatch("write_wait_ticks readback", cfg_prdata, wait_ticks);
            default: ;
          endcase
        end
      end
    end
    pending  = due_results.size();
    seq_busy = (seq_step != ST_IDLE);
  end

endmodule

FILE: bench/testbench.sv
// testbench top: tick stimulus, register settings and verdict for the i2c eeprom byte master
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cebm_pkg::*;

  // command value the block treats like a plain tick
  localparam logic [1:0] CMD_SPARE = 2'd3;

  // register byte addresses, index times four
  localparam logic [CFG_ADDR_W-1:0] DEV_REG_ADDR  = {REG_DEV_ADDR, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] WAIT_REG_ADDR = {REG_WAIT_TICK, 2'b00};

  // ticks from an accepted request to its completing tick
  localparam int READ_TICKS  = 156;
  localparam int WRITE_TICKS = 116;

  localparam int RANDOM_ITEMS = 800;

  // sda levels fed during a transfer
  localparam int SDA_LOW  = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RAND = 2;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;   // address[7:0], write_data[15:8], sda_in[16]
  logic [1:0]            in_tuser    = '0;   // command[1:0]
  logic                  in_tlast    = 1'b0; // final_byte
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;          // scl[0], sda_release[1], read_data[9:2],
                                             // busy_res[10], byte_done[11], burst_done[12],
                                             // rejected[13]
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [31:0]           cfg_pwdata  = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  int   errors;
  int   pending;
  logic seq_busy;

  // sender and receiver idling modes; calm means no gaps at all
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  int items_sent = 0;
  int cur_wait   = int'(WAIT_TICK_RESET);

  i2c_eeprom_byte_master_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  i2cebm_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .errors      (errors),
    .pending     (pending),
    .seq_busy    (seq_busy)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("[i2c_eeprom_byte_master_top] ERROR");
    $finish;
  end

  // result side: random stall before each result, with calm stretches
  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (taken % 50 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      stall = rx_calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  // one request on in_, after a random gap; returns at the accepting edge
  // valid stays high on return so back-to-back requests need no extra cycle
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] addr,
                           input logic [7:0] wd, input logic fin, input logic sda);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {7'd0, sda, wd, addr};
    in_tuser  <= cmd;
    in_tlast  <= fin;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // plain ticks with random payload; with poke set some carry requests,
  // which the block must reject while busy
  task automatic run_ticks(input int n, input bit poke, input int sda_mode);
    logic [1:0] cmd;
    logic       sda;
    for (int i = 0; i < n; i++) begin
      if (poke && $urandom_range(0, 4) == 0)
        cmd = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
      else
        cmd = ($urandom_range(0, 7) == 0) ? CMD_SPARE : CMD_TICK;
      case (sda_mode)
        SDA_LOW:  sda = 1'b0;
        SDA_HIGH: sda = 1'b1;
        default:  sda = 1'($urandom_range(0, 1));
      endcase
      send_item(cmd, 8'($urandom), 8'($urandom), 1'($urandom), sda);
    end
  endtask

  // one byte request followed by exactly enough ticks to complete it
  task automatic byte_xfer(input logic [1:0] cmd, input logic [7:0] addr,
                           input logic [7:0] wd, input logic fin, input int sda_mode);
    send_item(cmd, addr, wd, fin, 1'($urandom_range(0, 1)));
    run_ticks((cmd == CMD_READ) ? READ_TICKS : WRITE_TICKS + cur_wait, 1'b1, sda_mode);
  endtask

  // sender holds off until every predicted result has been taken;
  // called right at an accepting edge, ends on a rising edge
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // drain, then tick on until the predicted sequencer is idle again
  task automatic settle();
    drain();
    while (seq_busy) begin
      run_ticks(1, 1'b0, SDA_RAND);
      drain();
    end
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic reg_write(input logic [CFG_ADDR_W-1:0] a, input logic [31:0] d);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= a;
    cfg_pwdata  <= d;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // apb read; the checker compares prdata at the access edge
  task automatic reg_read(input logic [CFG_ADDR_W-1:0] a);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= a;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // wait count register; upper bits are junk the block must drop
  task automatic set_wait(input int w);
    reg_write(WAIT_REG_ADDR, {12'($urandom_range(0, 4095)), w[19:0]});
    cur_wait = w;
  endtask

  initial begin : stimulus
    int         rand_start;
    int         w;
    logic [1:0] cmd;
    // synchronous reset, held low and then released
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: idle ticks of both tick codes, then a read with sda high
    // and requests poked into the busy stretch
    send_item(CMD_TICK, 8'hff, 8'hff, 1'b1, 1'b1);
    send_item(CMD_SPARE, 8'h00, 8'h00, 1'b0, 1'b0);
    byte_xfer(CMD_READ, 8'h00, 8'hff, 1'b0, SDA_HIGH);
    drain();
    reg_read(DEV_REG_ADDR);
    reg_read(WAIT_REG_ADDR);

    // lowest device address, no write wait; burst offset wraps the address
    settle();
    reg_write(DEV_REG_ADDR, 32'hffff_ff80);
    set_wait(0);
    reg_read(DEV_REG_ADDR);
    reg_read(WAIT_REG_ADDR);
    byte_xfer(CMD_WRITE, 8'hff, 8'hff, 1'b1, SDA_RAND);
    byte_xfer(CMD_WRITE, 8'hff, 8'h00, 1'b0, SDA_RAND);
    byte_xfer(CMD_READ, 8'hff, 8'h00, 1'b1, SDA_LOW);

    // highest device address, shortest nonzero wait
    settle();
    reg_write(DEV_REG_ADDR, 32'h0000_007f);
    set_wait(1);
    byte_xfer(CMD_WRITE, 8'h80, 8'h80, 1'b0, SDA_RAND);
    byte_xfer(CMD_READ, 8'h7f, 8'h55, 1'b1, SDA_RAND);

    // longest wait: reads only, the wait never runs
    settle();
    reg_write(DEV_REG_ADDR, 32'hffff_ffff);
    set_wait(20'hfffff);
    reg_read(WAIT_REG_ADDR);
    run_ticks(4, 1'b0, SDA_RAND);
    byte_xfer(CMD_READ, 8'ha5, 8'h5a, 1'b0, SDA_RAND);

    // random phases: new settings, then well-formed bursts with noise around them
    rand_start = items_sent;
    while (items_sent - rand_start < RANDOM_ITEMS) begin
      settle();
      tx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1)) reg_write(DEV_REG_ADDR, $urandom);
      case ($urandom_range(0, 5))
        0:       w = 0;
        1:       w = 1;
        5:       w = $urandom_range(100, 400);
        default: w = $urandom_range(2, 40);
      endcase
      set_wait(w);
      if ($urandom_range(0, 3) == 0) begin
        reg_read(DEV_REG_ADDR);
        reg_read(WAIT_REG_ADDR);
      end
      repeat ($urandom_range(1, 3)) begin
        run_ticks($urandom_range(0, 4), 1'b0, SDA_RAND);
        cmd = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
        byte_xfer(cmd, 8'($urandom), 8'($urandom), $urandom_range(0, 2) == 0, SDA_RAND);
      end
    end

    // wind down: all results in, block idle, a few spare cycles for strays
    settle();
    repeat (16) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[i2c_eeprom_byte_master_top] OK");
    end else begin
      $display("[i2c_eeprom_byte_master_top] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/i2cebm_pkg.sv
rtl/i2c_eeprom_byte_master_top.sv
bench/i2cebm_checker.sv
bench/testbench.sv
